[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the datapath and controller RTL files of the square root block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// A property that must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// An antecedent that implies a consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/fpsr_pkg.sv]
// ----------------------------------------------------------------------------
// fpsr_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package fpsr_pkg;

    localparam int INPUT_BITS_DEF    = 31;
    localparam int FRACTION_BITS_DEF = 30;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
    } t_dp_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic last;
    } t_dp_stat;

endpackage

[rtl/fixed_point_square_root.sv]
// ----------------------------------------------------------------------------
// fixed_point_square_root
// Floor square root of an unsigned integer in unsigned fixed point.
//
//   channel   handshake            payload
//   input     start, busy          i_radicand   [INPUT_BITS-1:0]
//   result    o_valid (strobe)     o_root_fixed [ROOT_BITS-1:0]
//
// A word is taken at an edge with start high and busy low. The datapath then
// resolves one root bit per cycle with one compare and subtract, and the result
// strobe follows the final step. A new word may be started in the strobe cycle,
// but not while busy, so words do not overlap. Reset is synchronous and returns
// the controller to idle. The receiver cannot stall: each result is shown for
// one cycle only.
// ----------------------------------------------------------------------------
module fixed_point_square_root #(
    parameter int INPUT_BITS    = fpsr_pkg::INPUT_BITS_DEF,
    parameter int FRACTION_BITS = fpsr_pkg::FRACTION_BITS_DEF,
    localparam int ROOT_BITS    = (INPUT_BITS + 1) / 2 + FRACTION_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic [INPUT_BITS-1:0] i_radicand,
    output logic                  busy,
    output logic                  o_valid,
    output logic [ROOT_BITS-1:0]  o_root_fixed
);

    fpsr_pkg::t_dp_cmd  w_cmd;
    fpsr_pkg::t_dp_stat w_stat;

    fpsr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    fpsr_datapath #(
        .INPUT_BITS    (INPUT_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_radicand (i_radicand),
        .o_stat     (w_stat),
        .o_root     (o_root_fixed)
    );

endmodule

[rtl/fpsr_datapath.sv]
// ----------------------------------------------------------------------------
// fpsr_datapath
// Digit-by-digit square root datapath: one root bit per step.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fpsr_datapath #(
    parameter int INPUT_BITS    = fpsr_pkg::INPUT_BITS_DEF,
    parameter int FRACTION_BITS = fpsr_pkg::FRACTION_BITS_DEF,
    localparam int HALF_BITS    = (INPUT_BITS + 1) / 2,
    localparam int ROOT_BITS    = HALF_BITS + FRACTION_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fpsr_pkg::t_dp_cmd     i_cmd,
    input  logic [INPUT_BITS-1:0] i_radicand,
    output fpsr_pkg::t_dp_stat    o_stat,
    output logic [ROOT_BITS-1:0]  o_root
);

    localparam int RAD_W = 2 * HALF_BITS;
    localparam int REM_W = ROOT_BITS + 2;
    localparam int CNT_W = (ROOT_BITS > 1) ? $clog2(ROOT_BITS) : 1;

    logic [RAD_W-1:0]     r_rad, n_rad;
    logic [REM_W-1:0]     r_rem, n_rem;
    logic [ROOT_BITS-1:0] r_root, n_root;
    logic [CNT_W-1:0]     r_count, n_count;

    logic [REM_W-1:0] w_rem_sh;
    logic [REM_W-1:0] w_trial;
    logic             w_keep;

    // The radicand enters two bits per step, then zeros for the fraction part.
    assign w_rem_sh = {r_rem[ROOT_BITS-1:0], r_rad[RAD_W-1 -: 2]};
    assign w_trial  = {r_root, 2'b01};
    assign w_keep   = (w_rem_sh >= w_trial);

    always_comb begin
        n_rad   = r_rad;
        n_rem   = r_rem;
        n_root  = r_root;
        n_count = r_count;
        if (i_cmd.load) begin
            n_rad   = RAD_W'(i_radicand);
            n_rem   = '0;
            n_root  = '0;
            n_count = CNT_W'(ROOT_BITS - 1);
        end else if (i_cmd.step) begin
            n_rad   = r_rad << 2;
            n_rem   = w_keep ? (w_rem_sh - w_trial) : w_rem_sh;
            n_root  = (r_root << 1) | ROOT_BITS'(w_keep);
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_stat.last = (r_count == '0);
    assign o_root      = r_root;

    `ASSERT_IMPLIES(a_no_load_and_step, i_clk, i_rst_n, i_cmd.load, !i_cmd.step)
    `ASSERT_IMPLIES(a_count_reloads, i_clk, i_rst_n, $past(i_cmd.load),
        r_count == CNT_W'(ROOT_BITS - 1))
    `ASSERT_IMPLIES(a_rem_bounded, i_clk, i_rst_n, i_cmd.step,
        n_rem <= REM_W'({n_root, 1'b0}))

endmodule

[rtl/fpsr_ctrl.sv]
// ----------------------------------------------------------------------------
// fpsr_ctrl
// Controller for the square root block: load, step sequence and result strobe.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fpsr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  fpsr_pkg::t_dp_stat i_stat,
    output fpsr_pkg::t_dp_cmd  o_cmd,
    output logic               busy,
    output logic               o_valid
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] r_state, n_state;

    assign busy       = (r_state == ST_RUN);
    assign o_valid    = (r_state == ST_DONE);
    assign o_cmd.load = start && !busy;
    assign o_cmd.step = (r_state == ST_RUN);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) n_state = ST_RUN;
            end
            ST_RUN: begin
                if (i_stat.last) n_state = ST_DONE;
            end
            ST_DONE: begin
                // A new word may be taken while the result is on the ports.
                n_state = start ? ST_RUN : ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `ASSERT_IMPLIES(a_valid_not_busy, i_clk, i_rst_n, o_valid, !busy)
    `ASSERT_AT(a_valid_one_cycle, i_clk, i_rst_n, o_valid |=> !o_valid)
    `ASSERT_IMPLIES(a_valid_after_last, i_clk, i_rst_n, o_valid,
        $past(busy) && $past(i_stat.last))

endmodule
